### rtl/core/silc_pkg.sv
// Shared types and codes for the slotted infrared link controller.
// Depends on nothing; every other file in rtl/core imports it.
package silc_pkg;

  // Operation codes of a request.
  localparam logic [2:0] OP_FRAME_TICK   = 3'd0;
  localparam logic [2:0] OP_DATA_TICK    = 3'd1;
  localparam logic [2:0] OP_RX_CHAR      = 3'd2;
  localparam logic [2:0] OP_SERVICE      = 3'd3;
  localparam logic [2:0] OP_HOST_WRITE   = 3'd4;
  localparam logic [2:0] OP_HOST_READ    = 3'd5;
  localparam logic [2:0] OP_CLEAR_ERRORS = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_TX_BYTE = 2'd1;
  localparam logic [1:0] KIND_BREAK   = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Link phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_BREAK = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 1'd1;
  localparam logic [7:0] FRAME_BYTES_RST = 8'd16;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       rx_break;
    logic       rx_frame_error;
    logic       tx_room;
    logic       char_timeout;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic        read_valid;
    logic        accepted;
    logic        notify;
    logic        last;
    logic [6:0]  rx_count;
    logic [6:0]  tx_count;
    logic [31:0] error_count;
    logic [1:0]  link_phase;
  } res_t;

  // Classified command passed from the front to the back.
  typedef enum logic [3:0] {
    CMD_FRAME,
    CMD_DATA,
    CMD_RX_BREAK,
    CMD_RX_BYTE,
    CMD_RX_ERROR,
    CMD_SERVICE,
    CMD_HOST_WR,
    CMD_HOST_RD,
    CMD_CLEAR,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e       code;
    logic [7:0] data;
    logic       tx_room;
    logic       char_timeout;
  } cmd_t;

endpackage

### rtl/core/silc_front.sv
// Request front end: decodes each request into a command and holds it in a
// two-entry command queue for the back end. Depends on silc_pkg.
module silc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  silc_pkg::req_t req_i,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i,
  output silc_pkg::cmd_t cmd_o
);
  import silc_pkg::*;

  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_new;

  // Decode the operation; split a received character into break, byte or error.
  always_comb begin
    cmd_new.data         = req_i.data_byte;
    cmd_new.tx_room      = req_i.tx_room;
    cmd_new.char_timeout = req_i.char_timeout;
    case (req_i.operation)
      OP_FRAME_TICK:   cmd_new.code = CMD_FRAME;
      OP_DATA_TICK:    cmd_new.code = CMD_DATA;
      OP_RX_CHAR: begin
        if (req_i.rx_break) cmd_new.code = CMD_RX_BREAK;
        else if (!req_i.rx_frame_error) cmd_new.code = CMD_RX_BYTE;
        else cmd_new.code = CMD_RX_ERROR;
      end
      OP_SERVICE:      cmd_new.code = CMD_SERVICE;
      OP_HOST_WRITE:   cmd_new.code = CMD_HOST_WR;
      OP_HOST_READ:    cmd_new.code = CMD_HOST_RD;
      OP_CLEAR_ERRORS: cmd_new.code = CMD_CLEAR;
      default:         cmd_new.code = CMD_NOP;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/core/silc_back.sv
// Command back end: link state, byte FIFOs, error counter and result register.
// Depends on silc_pkg.
module silc_back #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned TX_BURST = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [silc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [silc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              cmd_valid_i,
  input  silc_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output silc_pkg::res_t                    res_o
);
  import silc_pkg::*;

  localparam int unsigned RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TCW = $clog2(TX_DEPTH + 1);
  localparam int unsigned BW  = $clog2(TX_BURST + 1);
  localparam int unsigned SW0 = (TCW > 8) ? TCW : 8;
  localparam int unsigned SW  = (SW0 > BW) ? SW0 : BW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TXRD = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [1:0]     phase_q, phase_d;
  logic [7:0]     burst_q, burst_d;
  logic [31:0]    err_q, err_d;
  logic           master_q;
  logic [7:0]     fbytes_q;
  logic [RAW-1:0] rx_rd_q, rx_rd_d;
  logic [RCW-1:0] rx_cnt_q, rx_cnt_d;
  logic [TAW-1:0] tx_rd_q, tx_rd_d;
  logic [TCW-1:0] tx_cnt_q, tx_cnt_d;
  logic [BW-1:0]  left_q, left_d;
  logic [1:0]     kind_q, kind_d;
  logic           rv_q, rv_d, acc_q, acc_d, note_q, note_d, send_q, send_d;
  logic           out_vld_q, out_load;
  res_t           out_q, res_new;

  logic [7:0]     rx_mem [RX_DEPTH];
  logic [7:0]     tx_mem [TX_DEPTH];
  logic [7:0]     rx_rdata_q, tx_rdata_q;
  logic           rx_we, tx_we, rx_re, tx_re;
  logic [RAW:0]   rx_sum;
  logic [TAW:0]   tx_sum;
  logic [RAW-1:0] rx_waddr;
  logic [TAW-1:0] tx_waddr;
  logic [SW-1:0]  tick_burst, svc_a, svc_n;

  // Tail of each FIFO: head plus count, wrapped once.
  always_comb begin
    rx_sum = {1'b0, rx_rd_q} + (RAW+1)'(rx_cnt_q);
    if (rx_sum >= (RAW+1)'(RX_DEPTH)) rx_sum = rx_sum - (RAW+1)'(RX_DEPTH);
    rx_waddr = rx_sum[RAW-1:0];
    tx_sum = {1'b0, tx_rd_q} + (TAW+1)'(tx_cnt_q);
    if (tx_sum >= (TAW+1)'(TX_DEPTH)) tx_sum = tx_sum - (TAW+1)'(TX_DEPTH);
    tx_waddr = tx_sum[TAW-1:0];
  end

  // Slot sizes: data tick caps at frame_bytes, service caps at the burst limit.
  always_comb begin
    tick_burst = (SW'(tx_cnt_q) < SW'(fbytes_q)) ? SW'(tx_cnt_q) : SW'(fbytes_q);
    svc_a      = (SW'(burst_q) < SW'(TX_BURST)) ? SW'(burst_q) : SW'(TX_BURST);
    svc_n      = (svc_a > SW'(tx_cnt_q)) ? SW'(tx_cnt_q) : svc_a;
  end

  assign empty_o  = !out_vld_q;
  assign res_o    = out_q;
  assign out_load = (state_q == ST_OUT) && (!out_vld_q || pop_i);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    burst_d   = burst_q;
    err_d     = err_q;
    rx_rd_d   = rx_rd_q;
    rx_cnt_d  = rx_cnt_q;
    tx_rd_d   = tx_rd_q;
    tx_cnt_d  = tx_cnt_q;
    left_d    = left_q;
    kind_d    = kind_q;
    rv_d      = rv_q;
    acc_d     = acc_q;
    note_d    = note_q;
    send_d    = send_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_re     = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_OUT;
          kind_d    = KIND_STATUS;
          rv_d      = 1'b0;
          acc_d     = 1'b0;
          note_d    = 1'b0;
          send_d    = 1'b0;
          case (cmd_i.code)
            CMD_FRAME: begin
              if (master_q || tx_cnt_q != '0) begin
                phase_d = PH_BREAK;
                kind_d  = KIND_BREAK;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            CMD_DATA: begin
              if (rx_cnt_q != '0 || tx_cnt_q != '0) begin
                burst_d = tick_burst[7:0];
                phase_d = PH_DATA;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            CMD_RX_BREAK: begin
              if (!master_q) begin
                phase_d = PH_WAIT;
                kind_d  = KIND_RESTART;
              end
            end
            CMD_RX_BYTE: begin
              if (rx_cnt_q < RCW'(RX_DEPTH)) begin
                rx_we    = 1'b1;
                rx_cnt_d = rx_cnt_q + 1'b1;
              end
            end
            CMD_RX_ERROR: err_d = err_q + 32'd1;
            CMD_SERVICE: begin
              note_d = (rx_cnt_q != '0) && ((phase_q == PH_DATA) || cmd_i.char_timeout);
              if (phase_q == PH_DATA && cmd_i.tx_room) begin
                burst_d = burst_q - svc_n[7:0];
                if (burst_q == svc_n[7:0]) phase_d = PH_IDLE;
                if (svc_n != '0) begin
                  // Counts go final now; the head pointer walks during the burst.
                  tx_cnt_d = tx_cnt_q - TCW'(svc_n);
                  left_d   = BW'(svc_n);
                  send_d   = 1'b1;
                  kind_d   = KIND_TX_BYTE;
                  state_d  = ST_TXRD;
                end
              end
            end
            CMD_HOST_WR: begin
              if (tx_cnt_q < TCW'(TX_DEPTH)) begin
                tx_we    = 1'b1;
                tx_cnt_d = tx_cnt_q + 1'b1;
                acc_d    = 1'b1;
              end
            end
            CMD_HOST_RD: begin
              if (rx_cnt_q != '0) begin
                rx_re    = 1'b1;
                rx_rd_d  = (rx_rd_q == RAW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
                rx_cnt_d = rx_cnt_q - 1'b1;
                rv_d     = 1'b1;
              end
            end
            CMD_CLEAR: err_d = '0;
            default: ;
          endcase
        end
      end
      ST_TXRD: begin
        tx_re   = 1'b1;
        tx_rd_d = (tx_rd_q == TAW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;
        left_d  = left_q - 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = (send_q && left_q != '0) ? ST_TXRD : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_new.kind        = kind_q;
    res_new.byte_out    = send_q ? tx_rdata_q : (rv_q ? rx_rdata_q : 8'd0);
    res_new.read_valid  = rv_q;
    res_new.accepted    = acc_q;
    res_new.notify      = note_q;
    res_new.last        = !send_q || (left_q == '0);
    res_new.rx_count    = 7'(rx_cnt_q);
    res_new.tx_count    = 7'(tx_cnt_q);
    res_new.error_count = err_q;
    res_new.link_phase  = phase_q;
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_waddr] <= cmd_i.data;
    if (rx_re) rx_rdata_q <= rx_mem[rx_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_waddr] <= cmd_i.data;
    if (tx_re) tx_rdata_q <= tx_mem[tx_rd_q];
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rv_q   <= rv_d;
    acc_q  <= acc_d;
    note_q <= note_d;
    left_q <= left_d;
    if (out_load) out_q <= res_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_IDLE;
      burst_q   <= '0;
      err_q     <= '0;
      master_q  <= 1'b0;
      fbytes_q  <= FRAME_BYTES_RST;
      rx_rd_q   <= '0;
      rx_cnt_q  <= '0;
      tx_rd_q   <= '0;
      tx_cnt_q  <= '0;
      send_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      burst_q  <= burst_d;
      err_q    <= err_d;
      rx_rd_q  <= rx_rd_d;
      rx_cnt_q <= rx_cnt_d;
      tx_rd_q  <= tx_rd_d;
      tx_cnt_q <= tx_cnt_d;
      send_q   <= send_d;
      if (out_load) out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MASTER_MODE: master_q <= cfg_wdata_i[0];
          CFG_FRAME_BYTES: fbytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/core/slotted_infrared_link_controller.sv
// Top level of the slotted infrared link controller.
// Depends on silc_pkg, silc_front and silc_back.
//
// Requests enter when push is high and full low; results leave when pop is
// high and empty low, res_o holding the oldest one. Every request gives one
// result, except a service in a data slot with tx_room and bytes to send, giving
// one transmit-byte result per byte (up to TX_BURST); last marks the final one.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 master_mode, 1 frame_bytes); write only while no request is in flight.
// Flow: a request is decoded as it enters the command queue; the back end
// takes it in ST_IDLE and updates its state registers, then loads the result
// register in ST_OUT, and takes the next command only after that load.
// In a burst, each byte is read in ST_TXRD through the transmit memory's
// registered read port, then loaded into the result register in ST_OUT.
// Reset: link idle, burst zero, error counter zero, both FIFOs empty,
//   master_mode 0, frame_bytes 16. FIFO storage is not cleared.
// Stall: a result not popped holds the back end; the two-entry command queue
//   then fills and full holds off further requests. Nothing is dropped.
module slotted_infrared_link_controller #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned TX_BURST = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  silc_pkg::req_t                  req_i,
  output logic                            empty,
  input  logic                            pop,
  output silc_pkg::res_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [silc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [silc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import silc_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Decode requests and buffer them ahead of the back end.
  silc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Carry out commands against link state and FIFOs; hold one result.
  silc_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH),
    .TX_BURST (TX_BURST)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule
